[sv/aes_pkg.sv]
package aes_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_KEY_LENGTH = 3'd0;
	localparam logic [2:0] REG_KEY_A      = 3'd1;
	localparam logic [2:0] REG_KEY_B      = 3'd2;
	localparam logic [2:0] REG_KEY_C      = 3'd3;
	localparam logic [2:0] REG_KEY_D      = 3'd4;

	localparam logic CMD_ENCRYPT = 1'b0;
	localparam logic CMD_DECRYPT = 1'b1;

	localparam int STORE_DEPTH = 15;

	// key length codes
	localparam logic [1:0] KLEN_128 = 2'd0;
	localparam logic [1:0] KLEN_192 = 2'd1;
	localparam logic [1:0] KLEN_256 = 2'd2;

	typedef logic [7:0]   byte_t;
	typedef logic [31:0]  word_t;
	typedef logic [127:0] blk_t;
	typedef logic [3:0]   rnd_t;

	// request from the top level to the key expander
	typedef struct packed {
		logic       start;
		logic [1:0] key_length;
	} kx_ctl_t;

	localparam byte_t FWD_SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam byte_t INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	function automatic byte_t xtime(input byte_t v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic word_t sub_word(input word_t w);
		return {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
	endfunction

	// round count for a key length code (code 3 acts as 256-bit)
	function automatic rnd_t num_rounds(input logic [1:0] kl);
		rnd_t n;
		n = 4'd14;
		if (kl == KLEN_128) n = 4'd10;
		else if (kl == KLEN_192) n = 4'd12;
		return n;
	endfunction

endpackage

[sv/aes_key_expand.sv]
// Key schedule: one 32-bit word per cycle into the round-key store.
module aes_key_expand (
	input  logic                clk,
	input  logic                arst_n,
	input  aes_pkg::kx_ctl_t    ctl,
	input  logic [255:0]        key,
	output logic                busy,
	input  aes_pkg::rnd_t       rd_idx,
	output aes_pkg::blk_t       rd_key
);

	// 128-bit rows; the key words are written at start, the rest one word at a time
	aes_pkg::word_t mem_q [aes_pkg::STORE_DEPTH][4];

	// sliding window of the last eight words
	aes_pkg::word_t win_q [8];
	logic [5:0]     i_q;
	logic [5:0]     total_q;
	logic [3:0]     nk_q;
	logic [2:0]     pos_q;
	aes_pkg::byte_t rc_q;
	logic           busy_q;

	aes_pkg::word_t prev_w, back_w, t_w, new_w;
	logic [3:0]     nk_d;

	always_comb begin
		unique case (ctl.key_length)
			aes_pkg::KLEN_128: nk_d = 4'd4;
			aes_pkg::KLEN_192: nk_d = 4'd6;
			default:           nk_d = 4'd8;
		endcase
	end

	// window holds w[i-8..i-1] in win_q[0..7]
	always_comb begin
		prev_w = win_q[7];
		back_w = win_q[3'(4'd8 - nk_q)];
		t_w = prev_w;
		if (pos_q == 3'd0)
			t_w = aes_pkg::sub_word({prev_w[23:0], prev_w[31:24]}) ^ {rc_q, 24'h0};
		else if (nk_q == 4'd8 && pos_q == 3'd4)
			t_w = aes_pkg::sub_word(prev_w);
		new_w = back_w ^ t_w;
	end

	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			i_q <= {2'b0, nk_d};
		end else if (busy_q) begin
			i_q <= i_q + 6'd1;
			if (i_q == total_q - 6'd1) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			nk_q <= nk_d;
			total_q <= 6'(4 * (int'(nk_d) + 7));
			rc_q <= 8'h01;
			pos_q <= '0;
			// preload window so the key words sit at its top
			for (int k = 0; k < 8; k++) begin
				if (k >= 8 - int'(nk_d))
					win_q[k] <= key[255 - 32 * (k - (8 - int'(nk_d))) -: 32];
				else
					win_q[k] <= '0;
			end
			for (int k = 0; k < 8; k++) begin
				if (k < int'(nk_d))
					mem_q[k >> 2][k & 3] <= key[255 - 32 * k -: 32];
			end
		end else if (busy_q) begin
			for (int k = 0; k < 7; k++) win_q[k] <= win_q[k + 1];
			win_q[7] <= new_w;
			mem_q[i_q[5:2]][i_q[1:0]] <= new_w;
			pos_q <= (pos_q == 3'(nk_q - 4'd1)) ? 3'd0 : pos_q + 3'd1;
			if (pos_q == 3'd0) rc_q <= aes_pkg::xtime(rc_q);
		end
	end

	always_ff @(posedge clk) begin
		rd_key <= {mem_q[rd_idx][0], mem_q[rd_idx][1], mem_q[rd_idx][2], mem_q[rd_idx][3]};
	end

endmodule

[sv/aes_round.sv]
// One shared round unit: forward or inverse round on a 128-bit state.
module aes_round (
	input  aes_pkg::blk_t st,
	input  aes_pkg::blk_t rkey,
	input  logic          decrypt,
	input  logic          last,
	output aes_pkg::blk_t res
);

	aes_pkg::byte_t s [16];
	aes_pkg::byte_t t [16];
	aes_pkg::byte_t u [16];
	aes_pkg::byte_t m [16];
	aes_pkg::byte_t a [16];
	aes_pkg::byte_t c0, c1, c2, c3, x0, x1, x2, x3, e0, e1;
	aes_pkg::byte_t k [16];

	always_comb begin
		for (int j = 0; j < 16; j++) begin
			s[j] = st[127 - 8 * j -: 8];
			k[j] = rkey[127 - 8 * j -: 8];
		end
		// shift rows then substitute (order commutes)
		for (int r = 0; r < 4; r++) begin
			for (int cc = 0; cc < 4; cc++) begin
				if (decrypt)
					t[r + 4 * ((cc + r) & 3)] = s[r + 4 * cc];
				else
					t[r + 4 * cc] = s[r + 4 * ((cc + r) & 3)];
			end
		end
		for (int j = 0; j < 16; j++)
			u[j] = decrypt ? aes_pkg::INV_SBOX[t[j]] : aes_pkg::FWD_SBOX[t[j]];
		// decrypt adds the key before inverse mix
		for (int j = 0; j < 16; j++) a[j] = decrypt ? (u[j] ^ k[j]) : u[j];
		// mix columns; inverse via forward mix after a preprocessing step
		for (int cc = 0; cc < 4; cc++) begin
			c0 = a[4 * cc]; c1 = a[4 * cc + 1]; c2 = a[4 * cc + 2]; c3 = a[4 * cc + 3];
			e0 = aes_pkg::xtime(aes_pkg::xtime(c0 ^ c2));
			e1 = aes_pkg::xtime(aes_pkg::xtime(c1 ^ c3));
			if (decrypt) begin
				c0 = c0 ^ e0; c2 = c2 ^ e0; c1 = c1 ^ e1; c3 = c3 ^ e1;
			end
			x0 = aes_pkg::xtime(c0); x1 = aes_pkg::xtime(c1);
			x2 = aes_pkg::xtime(c2); x3 = aes_pkg::xtime(c3);
			m[4 * cc]     = x0 ^ x1 ^ c1 ^ c2 ^ c3;
			m[4 * cc + 1] = c0 ^ x1 ^ x2 ^ c2 ^ c3;
			m[4 * cc + 2] = c0 ^ c1 ^ x2 ^ x3 ^ c3;
			m[4 * cc + 3] = x0 ^ c0 ^ c1 ^ c2 ^ x3;
		end
		for (int j = 0; j < 16; j++) begin
			if (last) res[127 - 8 * j -: 8] = u[j] ^ k[j];
			else if (decrypt) res[127 - 8 * j -: 8] = m[j];
			else res[127 - 8 * j -: 8] = m[j] ^ k[j];
		end
	end

endmodule

[sv/aes_block_cipher.sv]
// AES-128/192/256 ECB engine. Write key_length and key words A..D; every write
// (index 0..4) reruns the key schedule, one word a cycle, during which no
// block is taken. A block goes through one round-key store read, the initial
// key add, then one round per cycle through the shared round unit. The result
// sits in an output register; the next block is taken once it is taken.
module aes_block_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_high,
	output logic [63:0] result_low
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_FETCH = 4'b0010,
		ST_RUN   = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t           state_q;
	logic [1:0]       klen_q;
	logic [255:0]     key_q;
	logic             dec_q;
	logic             kx_start_q;
	aes_pkg::blk_t    st_q;
	aes_pkg::rnd_t    rnd_q;
	aes_pkg::rnd_t    nr;
	aes_pkg::rnd_t    rd_idx;
	aes_pkg::blk_t    rd_key, rnd_res;
	aes_pkg::kx_ctl_t kx_ctl;
	logic             kx_busy, cfg_fire, in_fire, cfg_hit, last;

	assign nr = aes_pkg::num_rounds(klen_q);
	assign cfg_ready = (state_q == ST_IDLE) && !kx_busy;
	assign cfg_fire = cfg_valid && cfg_ready;
	// a pending register write goes first
	assign in_stall = !((state_q == ST_IDLE) && !kx_busy && !kx_start_q && !cfg_valid);
	assign in_fire = in_valid && !in_stall;
	assign out_valid = (state_q == ST_DONE);
	assign result_high = st_q[127:64];
	assign result_low = st_q[63:0];
	assign last = (rnd_q == nr);
	assign cfg_hit = cfg_index <= aes_pkg::REG_KEY_D;

	// expansion starts the cycle after a register write lands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) kx_start_q <= 1'b0;
		else kx_start_q <= cfg_fire && cfg_hit;
	end
	assign kx_ctl = {kx_start_q, klen_q};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q <= '0;
			key_q <= '0;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				aes_pkg::REG_KEY_LENGTH: klen_q <= cfg_data[1:0];
				aes_pkg::REG_KEY_A:      key_q[255:192] <= cfg_data;
				aes_pkg::REG_KEY_B:      key_q[191:128] <= cfg_data;
				aes_pkg::REG_KEY_C:      key_q[127:64] <= cfg_data;
				aes_pkg::REG_KEY_D:      key_q[63:0] <= cfg_data;
				default: ;
			endcase
		end
	end

	// store read index: next round number, mirrored for decrypt
	always_comb begin
		if (state_q == ST_IDLE)
			rd_idx = command == aes_pkg::CMD_DECRYPT ? nr : 4'd0;
		else
			rd_idx = dec_q ? (nr - rnd_q - 4'd1) : (rnd_q + 4'd1);
	end

	aes_key_expand u_kx (
		.clk(clk), .arst_n(arst_n), .ctl(kx_ctl), .key(key_q), .busy(kx_busy),
		.rd_idx(rd_idx), .rd_key(rd_key)
	);

	aes_round u_round (
		.st(st_q), .rkey(rd_key), .decrypt(dec_q), .last(last), .res(rnd_res)
	);

	// round sequencer; the counter sits at 0 during the fetch so round 1's key is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_fire) begin
					state_q <= ST_FETCH;
					rnd_q <= '0;
				end
				ST_FETCH: begin
					state_q <= ST_RUN;
					rnd_q <= 4'd1;
				end
				ST_RUN: begin
					if (last) state_q <= ST_DONE;
					else rnd_q <= rnd_q + 4'd1;
				end
				ST_DONE: if (!out_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// state register
	always_ff @(posedge clk) begin
		if (in_fire) begin
			st_q <= {block_high, block_low};
			dec_q <= command;
		end else if (state_q == ST_FETCH) begin
			st_q <= st_q ^ rd_key;
		end else if (state_q == ST_RUN) begin
			st_q <= rnd_res;
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		kx_busy |-> (state_q == ST_IDLE))
		else $error("key expansion overlapped a block");
	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (rnd_q <= nr && rnd_q != 4'd0))
		else $error("round counter out of range");
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(result_high)))
		else $error("result changed while stalled");

endmodule

[tb/sv/aes_block_cipher_chk.sv]
`timescale 1ns / 100ps

// Watches the key, block and result channels of aes_block_cipher, keeps its own
// key schedule and cipher, and compares every result word with the oldest
// prediction.
module aes_block_cipher_chk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        command,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [63:0] result_high,
	input  logic [63:0] result_low,
	output int          fails,
	output int          pending
);

	// mirrored key registers and round-key store
	logic [1:0]    klen;
	logic [63:0]   key_reg [4];
	aes_pkg::blk_t round_keys [aes_pkg::STORE_DEPTH];
	aes_pkg::blk_t expected_blocks [$];

	function automatic aes_pkg::byte_t gf_double(input aes_pkg::byte_t a);
		return a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
	endfunction

	function automatic aes_pkg::byte_t gf_product(input aes_pkg::byte_t a,
			input aes_pkg::byte_t b);
		aes_pkg::byte_t acc;
		acc = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[0])
				acc ^= a;
			a = gf_double(a);
			b = b >> 1;
		end
		return acc;
	endfunction

	function automatic aes_pkg::word_t sbox_word(input aes_pkg::word_t w);
		aes_pkg::word_t r;
		for (int k = 0; k < 4; k++)
			r[8*k +: 8] = aes_pkg::FWD_SBOX[w[8*k +: 8]];
		return r;
	endfunction

	function automatic int key_word_count();
		if (klen == aes_pkg::KLEN_128)
			return 4;
		if (klen == aes_pkg::KLEN_192)
			return 6;
		return 8;
	endfunction

	// Rijndael key schedule; entries past the last round key keep old contents
	function automatic void expand_round_keys();
		aes_pkg::word_t w [60];
		aes_pkg::word_t t;
		aes_pkg::byte_t rcon;
		int nk;
		int total;
		nk = key_word_count();
		total = 4 * (nk + 7);
		rcon = 8'h01;
		for (int i = 0; i < nk; i++)
			w[i] = i[0] ? key_reg[i >> 1][31:0] : key_reg[i >> 1][63:32];
		for (int i = nk; i < total; i++) begin
			t = w[i-1];
			if (i % nk == 0) begin
				t = sbox_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
				rcon = gf_double(rcon);
			end else if (nk > 6 && i % nk == 4) begin
				t = sbox_word(t);
			end
			w[i] = w[i-nk] ^ t;
		end
		for (int i = 0; i < total; i++)
			round_keys[i >> 2][127 - 32*(i & 3) -: 32] = w[i];
	endfunction

	// full encrypt or decrypt of one block with the current round keys
	function automatic aes_pkg::blk_t cipher_block(input logic cmd, input aes_pkg::blk_t blk);
		aes_pkg::byte_t st [16];
		aes_pkg::byte_t tmp [16];
		aes_pkg::byte_t col [4];
		aes_pkg::byte_t coef [4];
		aes_pkg::blk_t res;
		int nr;
		nr = key_word_count() + 6;
		for (int j = 0; j < 16; j++)
			st[j] = blk[127 - 8*j -: 8];
		if (cmd == aes_pkg::CMD_ENCRYPT)
			coef = '{8'd2, 8'd3, 8'd1, 8'd1};
		else
			coef = '{8'd14, 8'd11, 8'd13, 8'd9};
		for (int step = 0; step <= nr; step++) begin
			int r;
			r = (cmd == aes_pkg::CMD_ENCRYPT) ? step : nr - step;
			if (step > 0) begin
				// shift rows, then substitute
				tmp = st;
				for (int rw = 0; rw < 4; rw++)
					for (int c = 0; c < 4; c++)
						if (cmd == aes_pkg::CMD_ENCRYPT)
							st[rw + 4*c] = tmp[rw + 4*((c + rw) & 3)];
						else
							st[rw + 4*((c + rw) & 3)] = tmp[rw + 4*c];
				for (int j = 0; j < 16; j++)
					st[j] = (cmd == aes_pkg::CMD_ENCRYPT) ? aes_pkg::FWD_SBOX[st[j]]
						: aes_pkg::INV_SBOX[st[j]];
			end
			// encrypt mixes before the key add, decrypt after it
			if (cmd == aes_pkg::CMD_ENCRYPT && step > 0 && step < nr) begin
				for (int c = 0; c < 4; c++) begin
					for (int k = 0; k < 4; k++)
						col[k] = st[4*c + k];
					for (int rw = 0; rw < 4; rw++) begin
						st[4*c + rw] = '0;
						for (int k = 0; k < 4; k++)
							st[4*c + rw] ^= gf_product(col[k], coef[(k + 4 - rw) & 3]);
					end
				end
			end
			for (int j = 0; j < 16; j++)
				st[j] ^= round_keys[r][127 - 8*j -: 8];
			if (cmd == aes_pkg::CMD_DECRYPT && step > 0 && step < nr) begin
				for (int c = 0; c < 4; c++) begin
					for (int k = 0; k < 4; k++)
						col[k] = st[4*c + k];
					for (int rw = 0; rw < 4; rw++) begin
						st[4*c + rw] = '0;
						for (int k = 0; k < 4; k++)
							st[4*c + rw] ^= gf_product(col[k], coef[(k + 4 - rw) & 3]);
					end
				end
			end
		end
		for (int j = 0; j < 16; j++)
			res[127 - 8*j -: 8] = st[j];
		return res;
	endfunction

	// channel monitor
	always @(posedge clk or negedge arst_n) begin
		aes_pkg::blk_t exp_blk;
		if (!arst_n) begin
			klen = '0;
			for (int i = 0; i < 4; i++)
				key_reg[i] = '0;
			for (int i = 0; i < aes_pkg::STORE_DEPTH; i++)
				round_keys[i] = '0;
			expected_blocks.delete();
			fails = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					aes_pkg::REG_KEY_LENGTH: begin
						klen = cfg_data[1:0];
						expand_round_keys();
					end
					aes_pkg::REG_KEY_A, aes_pkg::REG_KEY_B, aes_pkg::REG_KEY_C,
					aes_pkg::REG_KEY_D: begin
						key_reg[cfg_index - aes_pkg::REG_KEY_A] = cfg_data;
						expand_round_keys();
					end
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_blocks.push_back(cipher_block(command, {block_high, block_low}));
			if (out_valid && !out_stall) begin
				if (expected_blocks.size() == 0) begin
					$error("result word with nothing expected: %h %h", result_high, result_low);
					fails++;
				end else begin
					exp_blk = expected_blocks.pop_front();
					if (result_high !== exp_blk[127:64]) begin
						$error("result_high expected %h got %h", exp_blk[127:64], result_high);
						fails++;
					end
					if (result_low !== exp_blk[63:0]) begin
						$error("result_low expected %h got %h", exp_blk[63:0], result_low);
						fails++;
					end
				end
			end
		end
		pending = expected_blocks.size();
	end

endmodule

[tb/sv/aes_block_cipher_tb.sv]
`timescale 1ns / 100ps

module aes_block_cipher_tb;

	// indexes past the register list, ignored by the block
	localparam logic [2:0] REG_NONE = 3'd7;
	localparam logic [2:0] REG_SPARE = 3'd5;
	// key length code 3, which the block treats as 256-bit
	localparam logic [1:0] KLEN_ALIAS = 2'd3;
	localparam int CYCLE_LIMIT = 600000;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        command;
	logic [63:0] block_high;
	logic [63:0] block_low;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] result_high;
	logic [63:0] result_low;
	int          fails;
	int          pending;
	int          cycles = 0;
	int          burst_left;
	bit          no_gaps;
	bit          hold_go;

	aes_block_cipher dut (.*);

	aes_block_cipher_chk chk (.*);

	always #10 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// result side: stall pattern with changing density, plus one long hold on request
	initial begin
		int pct;
		bit held;
		pct = 0;
		held = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (cycles % 250 == 0)
				pct = $urandom_range(2) * 35;
			if (hold_go && !held) begin
				held = 1;
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
			end else begin
				out_stall <= ($urandom_range(99) < pct);
			end
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// load a key length and all four key words, then release the channel
	task automatic load_key(input logic [1:0] kl, input logic [63:0] ka, input logic [63:0] kb,
			input logic [63:0] kc, input logic [63:0] kd);
		reg_write(aes_pkg::REG_KEY_A, ka);
		reg_write(aes_pkg::REG_KEY_B, kb);
		reg_write(aes_pkg::REG_KEY_C, kc);
		reg_write(aes_pkg::REG_KEY_D, kd);
		reg_write(aes_pkg::REG_KEY_LENGTH, {62'd0, kl});
		cfg_valid <= 1'b0;
	endtask

	task automatic send_block(input logic cmd, input logic [63:0] hi, input logic [63:0] lo);
		in_valid   <= 1'b1;
		command    <= cmd;
		block_high <= hi;
		block_low  <= lo;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (!no_gaps) begin
			burst_left = burst_left - 1;
			if (burst_left <= 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(1, 12);
			end
		end
	endtask

	// stop offering words and wait until every result is back
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic random_block(input int mode);
		logic [63:0] hi;
		logic [63:0] lo;
		hi = rand64();
		lo = rand64();
		// sparse and dense patterns now and then
		case (mode)
			0: hi = hi & rand64() & rand64();
			1: lo = lo | rand64() | rand64();
			default: ;
		endcase
		send_block(1'($urandom_range(1)), hi, lo);
	endtask

	initial begin
		logic [1:0] kl;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		command = aes_pkg::CMD_ENCRYPT;
		block_high = '0;
		block_low = '0;
		burst_left = 4;
		no_gaps = 0;
		hold_go = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero key, 128-bit
		load_key(aes_pkg::KLEN_128, '0, '0, '0, '0);
		send_block(aes_pkg::CMD_ENCRYPT, '0, '0);
		send_block(aes_pkg::CMD_DECRYPT, '0, '0);
		send_block(aes_pkg::CMD_ENCRYPT, '1, '1);
		send_block(aes_pkg::CMD_DECRYPT, '1, '1);
		send_block(aes_pkg::CMD_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
		drain();

		// directed: all-ones key, 192-bit; the unused word carries junk
		load_key(aes_pkg::KLEN_192, '1, '1, '1, 64'h5a5a_a5a5_0f0f_f0f0);
		send_block(aes_pkg::CMD_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001);
		send_block(aes_pkg::CMD_DECRYPT, 64'h0000000000000001, 64'h8000000000000000);
		send_block(aes_pkg::CMD_ENCRYPT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
		send_block(aes_pkg::CMD_DECRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
		drain();

		// directed: 256-bit, then code 3 which acts as 256-bit
		load_key(aes_pkg::KLEN_256, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
			64'h1011121314151617, 64'h18191a1b1c1d1e1f);
		send_block(aes_pkg::CMD_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
		send_block(aes_pkg::CMD_DECRYPT, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
		send_block(aes_pkg::CMD_ENCRYPT, '1, '0);
		drain();
		load_key(KLEN_ALIAS, rand64(), rand64(), rand64(), rand64());
		// writes past the register list are dropped
		reg_write(REG_NONE, '1);
		reg_write(REG_SPARE, rand64());
		cfg_valid <= 1'b0;
		send_block(aes_pkg::CMD_ENCRYPT, '0, '1);
		send_block(aes_pkg::CMD_DECRYPT, '1, '0);
		drain();

		// random phases with fresh keys
		for (int ph = 0; ph < 8; ph++) begin
			kl = (ph < 4) ? ph[1:0] : 2'($urandom_range(3));
			if (ph == 6) begin
				// only some registers change here
				reg_write(aes_pkg::REG_KEY_LENGTH, {62'd0, kl});
				if ($urandom_range(1))
					reg_write(aes_pkg::REG_KEY_C, rand64());
				cfg_valid <= 1'b0;
			end else begin
				load_key(kl, rand64(), rand64(), rand64(), rand64());
			end
			no_gaps = (ph % 3 == 2);
			for (int n = 0; n < 100; n++) begin
				if (ph == 2 && n == 10)
					hold_go = 1;
				if (ph == 4 && n == 50)
					drain();
				random_block($urandom_range(4));
			end
			drain();
		end

		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
